@@ rtl/bqe_pkg.sv @@
// Billboard quad expander: shared types and constants.
// No dependencies; used by every module of the block.
package bqe_pkg;

  localparam int BQE_QUEUE_DEPTH = 2;
  localparam logic [47:0] BQE_CAM_RESET = 48'h4000_0000_0000;
  localparam logic [1:0] BQE_LAST_CORNER = 2'd3;

  typedef enum logic {
    OP_GIVEN  = 1'b0,
    OP_DERIVE = 1'b1
  } bqe_op_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CROSS,
    F_MAG,
    F_SQR,
    F_SUM,
    F_SQRT,
    F_DIV,
    F_PUSH
  } bqe_fstate_t;

  // One sprite as handed from front to back.
  typedef struct packed {
    logic [47:0]        up_axis;
    logic [47:0]        right_axis;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        half_width;
    logic [30:0]        half_height;
    logic signed [15:0] sin_angle;
    logic signed [15:0] cos_angle;
    logic [31:0]        color;
    logic [63:0]        tex_rect;
  } bqe_item_t;

  // Fields carried alongside the axis math in the back end.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        color;
    logic [63:0]        tex_rect;
  } bqe_pass_t;

endpackage

@@ rtl/bqe_queue.sv @@
// Billboard quad expander: small register queue between front and back.
// Depends on bqe_pkg for the item type.
module bqe_queue #(
  parameter int DEPTH = bqe_pkg::BQE_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  bqe_pkg::bqe_item_t  wr_data,
  output logic                full,
  input  logic                rd_en,
  output bqe_pkg::bqe_item_t  rd_data,
  output logic                valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  bqe_pkg::bqe_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_data = mem[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/bqe_front.sv @@
// Billboard quad expander: front end. Accepts sprites, holds the camera
// register, derives the right axis in mode 1. Depends on bqe_pkg.
module bqe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic                in_opcode,
  input  bqe_pkg::bqe_item_t  in_item,
  input  logic                cfg_we,
  input  logic [47:0]         cfg_camera_direction,
  output logic                q_wr,
  output bqe_pkg::bqe_item_t  q_wdata,
  input  logic                q_full
);

  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [3:0] DIV_LAST  = 4'd15;

  bqe_pkg::bqe_fstate_t state_r, state_nxt;
  bqe_pkg::bqe_item_t   hold_r;
  logic [47:0]          cam_r;

  logic signed [31:0] pa_r [3];
  logic signed [31:0] pb_r [3];
  logic [31:0]        cmag_r [3];
  logic               cneg_r [3];
  logic [63:0]        sq_r [3];
  logic [63:0]        s_r;
  logic [32:0]        rem_r;
  logic [31:0]        root_r;
  logic [31:0]        q_r;
  logic [31:0]        drem_r [3];
  logic [15:0]        dq_r [3];
  logic [4:0]         cnt_r;

  logic signed [15:0] tl [3];
  logic signed [15:0] cl [3];
  logic signed [32:0] diff [3];
  logic [63:0]        s_sum;
  logic [34:0]        rem_sh, trial;
  logic               sq_ge;
  logic [32:0]        rem_nxt;
  logic [31:0]        root_nxt;
  logic [32:0]        dsh [3];
  logic               dge [3];
  logic [31:0]        drem_nxt [3];
  logic [15:0]        dq_nxt [3];
  logic               ovf [3];
  logic [47:0]        rnorm;

  function automatic logic [15:0] norm_lane(input logic neg, input logic big,
                                            input logic [15:0] m);
    logic [15:0] res;
    if (neg) begin
      res = (big || m > 16'd32768) ? 16'h8000 : (~m + 16'd1);
    end else begin
      res = (big || m > 16'd32767) ? 16'h7fff : m;
    end
    return res;
  endfunction

  // lane views, cross differences, square-root and divider steps
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tl[i]   = $signed(hold_r.up_axis[16*i +: 16]);
      cl[i]   = $signed(cam_r[16*i +: 16]);
      diff[i] = 33'(pa_r[i]) - 33'(pb_r[i]);
    end
    s_sum    = sq_r[0] + sq_r[1] + sq_r[2];
    rem_sh   = {rem_r, s_r[63:62]};
    trial    = {1'b0, root_r, 2'b01};
    sq_ge    = (rem_sh >= trial);
    rem_nxt  = sq_ge ? 33'(rem_sh - trial) : rem_sh[32:0];
    root_nxt = {root_r[30:0], sq_ge};
    for (int i = 0; i < 3; i++) begin
      dsh[i]      = {drem_r[i], dq_r[i][15]};
      dge[i]      = (dsh[i] >= {1'b0, q_r});
      drem_nxt[i] = dge[i] ? 32'(dsh[i] - {1'b0, q_r}) : dsh[i][31:0];
      dq_nxt[i]   = {dq_r[i][14:0], dge[i]};
      // quotient would not fit 16 bits: |c| >= 4q
      ovf[i]      = ({2'b00, cmag_r[i]} >= {q_r, 2'b00});
      rnorm[16*i +: 16] = norm_lane(cneg_r[i], ovf[i], dq_nxt[i]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    full      = 1'b1;
    q_wr      = 1'b0;
    q_wdata   = hold_r;
    case (state_r)
      bqe_pkg::F_IDLE: begin
        full = q_full;
        if (push && !q_full) begin
          if (in_opcode == bqe_pkg::OP_GIVEN) begin
            q_wr    = 1'b1;
            q_wdata = in_item;
          end else begin
            state_nxt = bqe_pkg::F_CROSS;
          end
        end
      end
      bqe_pkg::F_CROSS: state_nxt = bqe_pkg::F_MAG;
      bqe_pkg::F_MAG:   state_nxt = bqe_pkg::F_SQR;
      bqe_pkg::F_SQR:   state_nxt = bqe_pkg::F_SUM;
      bqe_pkg::F_SUM: begin
        state_nxt = (s_sum == '0) ? bqe_pkg::F_PUSH : bqe_pkg::F_SQRT;
      end
      bqe_pkg::F_SQRT: begin
        if (cnt_r == SQRT_LAST) state_nxt = bqe_pkg::F_DIV;
      end
      bqe_pkg::F_DIV: begin
        if (cnt_r[3:0] == DIV_LAST) state_nxt = bqe_pkg::F_PUSH;
      end
      bqe_pkg::F_PUSH: begin
        q_wr = !q_full;
        if (!q_full) state_nxt = bqe_pkg::F_IDLE;
      end
      default: state_nxt = bqe_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bqe_pkg::F_IDLE;
      cam_r   <= bqe_pkg::BQE_CAM_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cam_r <= cfg_camera_direction;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      bqe_pkg::F_IDLE: begin
        if (push && !q_full) hold_r <= in_item;
      end
      bqe_pkg::F_CROSS: begin
        pa_r[0] <= tl[1] * cl[2];
        pb_r[0] <= tl[2] * cl[1];
        pa_r[1] <= tl[2] * cl[0];
        pb_r[1] <= tl[0] * cl[2];
        pa_r[2] <= tl[0] * cl[1];
        pb_r[2] <= tl[1] * cl[0];
      end
      bqe_pkg::F_MAG: begin
        for (int i = 0; i < 3; i++) begin
          cneg_r[i] <= diff[i][32];
          cmag_r[i] <= diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
        end
      end
      bqe_pkg::F_SQR: begin
        for (int i = 0; i < 3; i++) begin
          sq_r[i] <= {32'b0, cmag_r[i]} * {32'b0, cmag_r[i]};
        end
      end
      bqe_pkg::F_SUM: begin
        if (s_sum == '0) begin
          hold_r.right_axis <= '0;
        end else begin
          s_r    <= s_sum;
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
        end
      end
      bqe_pkg::F_SQRT: begin
        s_r    <= {s_r[61:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == SQRT_LAST) begin
          q_r   <= root_nxt;
          cnt_r <= '0;
          for (int i = 0; i < 3; i++) begin
            drem_r[i] <= {2'b00, cmag_r[i][31:2]};
            dq_r[i]   <= {cmag_r[i][1:0], 14'b0};
          end
        end
      end
      bqe_pkg::F_DIV: begin
        cnt_r <= cnt_r + 5'd1;
        for (int i = 0; i < 3; i++) begin
          drem_r[i] <= drem_nxt[i];
          dq_r[i]   <= dq_nxt[i];
        end
        if (cnt_r[3:0] == DIV_LAST) hold_r.right_axis <= rnorm;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/bqe_back.sv @@
// Billboard quad expander: back end. Rotates and scales the axes in a
// three-stage pipeline, then emits four corners. Depends on bqe_pkg.
module bqe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  bqe_pkg::bqe_item_t  q_item,
  output logic                q_rd,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  out_vert_x,
  output logic signed [31:0]  out_vert_y,
  output logic signed [31:0]  out_vert_z,
  output logic [31:0]         out_vert_color,
  output logic [15:0]         out_tex_u,
  output logic [15:0]         out_tex_v,
  output logic [1:0]          out_corner_index,
  output logic                out_last_corner
);

  localparam logic signed [63:0] RND_HALF = 64'sd134217728;
  localparam logic signed [37:0] SAT_MAX  = 38'sd2147483647;
  localparam logic signed [37:0] SAT_MIN  = -38'sd2147483648;

  logic s1_v_r, s2_v_r, s3_v_r, em_v_r, out_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, em_free, em_load, out_load, last_done;

  logic signed [32:0] mr_r [3];
  logic signed [32:0] mt_r [3];
  logic [30:0]        w_r, h_r;
  bqe_pkg::bqe_pass_t s1_pass_r, s2_pass_r, s3_pass_r, em_pass_r;

  logic signed [63:0] pr_r [3];
  logic signed [63:0] pt_r [3];
  logic signed [35:0] vr_r [3];
  logic signed [35:0] vt_r [3];
  logic signed [36:0] a_r [3];
  logic signed [36:0] b_r [3];
  logic [1:0]         cnt_r;

  logic signed [15:0] tl [3];
  logic signed [15:0] rl [3];
  logic signed [31:0] p_ts [3];
  logic signed [31:0] p_rc [3];
  logic signed [31:0] p_tc [3];
  logic signed [31:0] p_rs [3];
  logic signed [31:0] ws, hs;
  logic signed [63:0] pr_c [3];
  logic signed [63:0] pt_c [3];
  logic signed [63:0] rr [3];
  logic signed [63:0] rt [3];
  logic signed [31:0] pos [3];
  logic signed [37:0] off [3];
  logic signed [37:0] corner [3];
  logic signed [31:0] vert [3];

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] res;
    if (v > SAT_MAX) begin
      res = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // handshake chain: a stage loads when it is empty or its content moves on
  assign out_load  = em_v_r && (!out_v_r || pop);
  assign last_done = out_load && (cnt_r == bqe_pkg::BQE_LAST_CORNER);
  assign em_free   = !em_v_r || last_done;
  assign em_load   = s3_v_r && em_free;
  assign s3_rdy    = !s3_v_r || em_load;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign q_rd      = q_valid && s1_rdy;
  assign empty     = !out_v_r;

  always_comb begin
    ws = $signed({1'b0, w_r});
    hs = $signed({1'b0, h_r});
    pos[0] = em_pass_r.pos_x;
    pos[1] = em_pass_r.pos_y;
    pos[2] = em_pass_r.pos_z;
    for (int i = 0; i < 3; i++) begin
      tl[i]   = $signed(q_item.up_axis[16*i +: 16]);
      rl[i]   = $signed(q_item.right_axis[16*i +: 16]);
      p_ts[i] = tl[i] * q_item.sin_angle;
      p_rc[i] = rl[i] * q_item.cos_angle;
      p_tc[i] = tl[i] * q_item.cos_angle;
      p_rs[i] = rl[i] * q_item.sin_angle;
      pr_c[i] = ws * mr_r[i];
      pt_c[i] = hs * mt_r[i];
      rr[i]   = pr_r[i] + RND_HALF;
      rt[i]   = pt_r[i] + RND_HALF;
      // corner order: -b, +a, -a, +b
      case (cnt_r)
        2'd0:    off[i] = -38'(b_r[i]);
        2'd1:    off[i] = 38'(a_r[i]);
        2'd2:    off[i] = -38'(a_r[i]);
        default: off[i] = 38'(b_r[i]);
      endcase
      corner[i] = 38'(pos[i]) + off[i];
      vert[i]   = sat32(corner[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      em_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (s1_rdy) s1_v_r <= q_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      em_v_r  <= em_load || (em_v_r && !last_done);
      out_v_r <= out_load || (out_v_r && !pop);
      if (em_load) begin
        cnt_r <= '0;
      end else if (out_load) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      for (int i = 0; i < 3; i++) begin
        mr_r[i] <= 33'(p_ts[i]) + 33'(p_rc[i]);
        mt_r[i] <= 33'(p_tc[i]) - 33'(p_rs[i]);
      end
      w_r       <= q_item.half_width;
      h_r       <= q_item.half_height;
      s1_pass_r <= '{pos_x: q_item.pos_x, pos_y: q_item.pos_y, pos_z: q_item.pos_z,
                     color: q_item.color, tex_rect: q_item.tex_rect};
    end
    if (s2_rdy) begin
      for (int i = 0; i < 3; i++) begin
        pr_r[i] <= pr_c[i];
        pt_r[i] <= pt_c[i];
      end
      s2_pass_r <= s1_pass_r;
    end
    if (s3_rdy) begin
      for (int i = 0; i < 3; i++) begin
        vr_r[i] <= rr[i][63:28];
        vt_r[i] <= rt[i][63:28];
      end
      s3_pass_r <= s2_pass_r;
    end
    if (em_load) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i] <= 37'(vt_r[i]) - 37'(vr_r[i]);
        b_r[i] <= 37'(vt_r[i]) + 37'(vr_r[i]);
      end
      em_pass_r <= s3_pass_r;
    end
    if (out_load) begin
      out_vert_x       <= vert[0];
      out_vert_y       <= vert[1];
      out_vert_z       <= vert[2];
      out_vert_color   <= em_pass_r.color;
      out_tex_u        <= cnt_r[1] ? em_pass_r.tex_rect[47:32] : em_pass_r.tex_rect[15:0];
      out_tex_v        <= cnt_r[0] ? em_pass_r.tex_rect[31:16] : em_pass_r.tex_rect[63:48];
      out_corner_index <= cnt_r;
      out_last_corner  <= (cnt_r == bqe_pkg::BQE_LAST_CORNER);
    end
  end

endmodule

@@ rtl/billboard_quad_expander_core.sv @@
// Billboard quad expander: top level.
// Depends on bqe_pkg, bqe_front, bqe_queue and bqe_back.
//
// Usage
//   Input is a queue write port: a sprite transaction happens on a clock
//   edge with push high and full low. Results are a queue read port: while
//   empty is low the oldest corner vertex sits on the out_ ports, and it is
//   taken on an edge with pop high. Each sprite yields four vertices in the
//   order -b, +a, -a, +b; last_corner flags the fourth.
//   The camera register is written through cfg_we / cfg_camera_direction;
//   the user must write it only while idle (not enforced); reset sets it to (0, 0, 1.0).
// Timing
//   Mode 0 sprites go straight into the front/back queue; with pop held
//   high a sprite passes the queue, stages s1 to s3, the emitter and the
//   output register; later sprites follow while earlier ones are in flight,
//   paced by the four-vertex emitter behind the single output register.
//   Mode 1 sprites run through the front sequencer: cross product, squared
//   length, a bit-serial square root and a three-lane serial divider. Full
//   stays high from the push until the sprite is written into the queue from
//   the push state; its first vertex then passes the back end as in mode 0.
//   A zero cross product skips the root and divide and queues a zero right
//   axis.
// Reset and stall
//   Synchronous active-low reset empties the queue and all stages; no
//   vertex is lost or repeated when pop is held low, the pipeline simply
//   fills and full rises once the queue has no room.
module billboard_quad_expander_core #(
  parameter int QUEUE_DEPTH = bqe_pkg::BQE_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_opcode,
  input  logic [47:0]        in_up_axis,
  input  logic [47:0]        in_right_axis,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [30:0]        in_half_width,
  input  logic [30:0]        in_half_height,
  input  logic signed [15:0] in_sin_angle,
  input  logic signed [15:0] in_cos_angle,
  input  logic [31:0]        in_color,
  input  logic [63:0]        in_tex_rect,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_vert_x,
  output logic signed [31:0] out_vert_y,
  output logic signed [31:0] out_vert_z,
  output logic [31:0]        out_vert_color,
  output logic [15:0]        out_tex_u,
  output logic [15:0]        out_tex_v,
  output logic [1:0]         out_corner_index,
  output logic               out_last_corner,
  input  logic               cfg_we,
  input  logic [47:0]        cfg_camera_direction
);

  bqe_pkg::bqe_item_t in_item, q_wdata, q_rdata;
  logic q_wr, q_full, q_rd, q_valid;

  // pack the sprite fields once; the front may replace the right axis
  assign in_item = '{up_axis: in_up_axis, right_axis: in_right_axis,
                     pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z,
                     half_width: in_half_width, half_height: in_half_height,
                     sin_angle: in_sin_angle, cos_angle: in_cos_angle,
                     color: in_color, tex_rect: in_tex_rect};

  bqe_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_opcode            (in_opcode),
    .in_item              (in_item),
    .cfg_we               (cfg_we),
    .cfg_camera_direction (cfg_camera_direction),
    .q_wr                 (q_wr),
    .q_wdata              (q_wdata),
    .q_full               (q_full)
  );

  bqe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .valid   (q_valid)
  );

  bqe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_rdata),
    .q_rd             (q_rd),
    .empty            (empty),
    .pop              (pop),
    .out_vert_x       (out_vert_x),
    .out_vert_y       (out_vert_y),
    .out_vert_z       (out_vert_z),
    .out_vert_color   (out_vert_color),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_corner_index (out_corner_index),
    .out_last_corner  (out_last_corner)
  );

endmodule

@@ tb/tb_billboard_quad_expander_core.sv @@
// Testbench for billboard_quad_expander_core: sprites in, corner vertices out.
// Depends on bqe_pkg and the block's RTL; a built-in predictor checks every vertex.
module tb_billboard_quad_expander_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_opcode = 1'b0;
  logic [47:0] in_up_axis = '0;
  logic [47:0] in_right_axis = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [30:0] in_half_width = '0, in_half_height = '0;
  logic signed [15:0] in_sin_angle = '0, in_cos_angle = '0;
  logic [31:0] in_color = '0;
  logic [63:0] in_tex_rect = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] out_vert_x, out_vert_y, out_vert_z;
  logic [31:0] out_vert_color;
  logic [15:0] out_tex_u, out_tex_v;
  logic [1:0] out_corner_index;
  logic out_last_corner;
  logic cfg_we = 1'b0;
  logic [47:0] cfg_camera_direction = '0;

  // One expected corner vertex.
  typedef struct {
    logic signed [31:0] x, y, z;
    logic [31:0] color;
    logic [15:0] u, v;
    logic [1:0] idx;
    logic last;
  } vertex_t;

  vertex_t vertex_q[$];
  logic [47:0] camera_dir;   // predictor copy of the camera register
  int errors = 0;
  longint cycles = 0;
  bit sender_quiet = 0;      // no idling on the input side
  bit receiver_quiet = 0;    // no stalls on the output side

  localparam longint CYCLE_LIMIT = 400000;

  always #10 clk = ~clk;

  billboard_quad_expander_core dut (.*);

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---- predictor -----------------------------------------------------------
  function automatic longint lane(logic [47:0] v, int i);
    logic signed [15:0] s;
    s = v[16*i +: 16];
    return longint'(s);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Scale c to Q1.14 by the root q, truncating the magnitude, then saturate.
  function automatic longint unit_lane(longint c, longint unsigned q);
    longint unsigned m;
    m = (longint'(abs64(c)) << 14) / q;
    if (c < 0) return (m > 32768) ? -32768 : -longint'(m);
    return (m > 32767) ? 32767 : longint'(m);
  endfunction

  // floor((v + 2^27) / 2^28); arithmetic shift is floor division.
  function automatic longint round_q28(longint v);
    return (v + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Work out the four corner vertices of one sprite.
  task automatic expand_sprite(bqe_pkg::bqe_op_t op, logic [47:0] up, logic [47:0] rt,
                               logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz, logic [30:0] hw, logic [30:0] hh,
                               logic signed [15:0] sn, logic signed [15:0] cs,
                               logic [31:0] col, logic [63:0] tex);
    longint t[3], r[3], c[3], p[3], vr[3], vt[3], a, b, off;
    longint unsigned s, q;
    logic [15:0] tu[4], tv[4];
    vertex_t vx;
    for (int i = 0; i < 3; i++) begin
      t[i] = lane(up, i);
      r[i] = lane(rt, i);
    end
    p[0] = px; p[1] = py; p[2] = pz;
    if (op == bqe_pkg::OP_DERIVE) begin
      c[0] = t[1] * lane(camera_dir, 2) - t[2] * lane(camera_dir, 1);
      c[1] = t[2] * lane(camera_dir, 0) - t[0] * lane(camera_dir, 2);
      c[2] = t[0] * lane(camera_dir, 1) - t[1] * lane(camera_dir, 0);
      s = 0;
      for (int i = 0; i < 3; i++) s += longint'(abs64(c[i])) * longint'(abs64(c[i]));
      if (s != 0) begin
        q = int_sqrt(s);
        for (int i = 0; i < 3; i++) r[i] = unit_lane(c[i], q);
      end else begin
        r[0] = 0; r[1] = 0; r[2] = 0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      vr[i] = round_q28(longint'(hw) * (t[i] * sn + r[i] * cs));
      vt[i] = round_q28(longint'(hh) * (t[i] * cs - r[i] * sn));
    end
    tu[0] = tex[15:0];  tv[0] = tex[63:48];
    tu[1] = tex[15:0];  tv[1] = tex[31:16];
    tu[2] = tex[47:32]; tv[2] = tex[63:48];
    tu[3] = tex[47:32]; tv[3] = tex[31:16];
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        a = vt[i] - vr[i];
        b = vt[i] + vr[i];
        case (k)
          0: off = -b;
          1: off = a;
          2: off = -a;
          default: off = b;
        endcase
        if (i == 0) vx.x = clamp32(p[i] + off);
        else if (i == 1) vx.y = clamp32(p[i] + off);
        else vx.z = clamp32(p[i] + off);
      end
      vx.color = col;
      vx.u = tu[k];
      vx.v = tv[k];
      vx.idx = k[1:0];
      vx.last = (k[1:0] == bqe_pkg::BQE_LAST_CORNER);
      vertex_q.push_back(vx);
    end
  endtask

  // ---- driving -------------------------------------------------------------
  function automatic bit sender_idles();
    return !sender_quiet && ($urandom_range(99) < 31);
  endfunction

  // Send one sprite transaction; predicted vertices are queued on acceptance.
  // push stays high afterwards until the next idle cycle or drain.
  task automatic send_sprite(bqe_pkg::bqe_op_t op, logic [47:0] up, logic [47:0] rt,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic [30:0] hw, logic [30:0] hh,
                             logic signed [15:0] sn, logic signed [15:0] cs,
                             logic [31:0] col, logic [63:0] tex);
    while (sender_idles()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_opcode <= op;
    in_up_axis <= up;
    in_right_axis <= rt;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_half_width <= hw; in_half_height <= hh;
    in_sin_angle <= sn; in_cos_angle <= cs;
    in_color <= col;
    in_tex_rect <= tex;
    do @(posedge clk); while (full);
    expand_sprite(op, up, rt, px, py, pz, hw, hh, sn, cs, col, tex);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [47:0] rand_axis();
    // Lanes within about +/-1.0 most of the time, raw patterns otherwise.
    logic [47:0] v;
    if ($urandom_range(3) == 0) return rand48();
    for (int i = 0; i < 3; i++) v[16*i +: 16] = 16'($signed($urandom_range(32768)) - 16384);
    return v;
  endfunction

  function automatic logic [15:0] rand_angle();
    if ($urandom_range(4) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [30:0] rand_scale();
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(32'h0010_0000));
      default: return 31'($urandom_range(32'h0100_0000));
    endcase
  endfunction

  task automatic send_random(bqe_pkg::bqe_op_t op);
    send_sprite(op, rand_axis(), rand_axis(), $urandom, $urandom, $urandom,
                rand_scale(), rand_scale(), rand_angle(), rand_angle(),
                $urandom, {$urandom, $urandom});
  endtask

  // Wait until every vertex is back, plus a margin, before touching the register.
  task automatic drain();
    push <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_camera(logic [47:0] v);
    cfg_we <= 1'b1;
    cfg_camera_direction <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    camera_dir = v;
  endtask

  // ---- result side ---------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n)
      pop <= receiver_quiet ? 1'b1 : ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && pop && !empty) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: vertex with no sprite pending, got x=%h", $realtime, out_vert_x);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (out_vert_x !== e.x) begin
          $display("%0t: vert_x exp %h got %h", $realtime, e.x, out_vert_x); errors++;
        end
        if (out_vert_y !== e.y) begin
          $display("%0t: vert_y exp %h got %h", $realtime, e.y, out_vert_y); errors++;
        end
        if (out_vert_z !== e.z) begin
          $display("%0t: vert_z exp %h got %h", $realtime, e.z, out_vert_z); errors++;
        end
        if (out_vert_color !== e.color) begin
          $display("%0t: vert_color exp %h got %h", $realtime, e.color, out_vert_color);
          errors++;
        end
        if (out_tex_u !== e.u) begin
          $display("%0t: tex_u exp %h got %h", $realtime, e.u, out_tex_u); errors++;
        end
        if (out_tex_v !== e.v) begin
          $display("%0t: tex_v exp %h got %h", $realtime, e.v, out_tex_v); errors++;
        end
        if (out_corner_index !== e.idx) begin
          $display("%0t: corner_index exp %0d got %0d", $realtime, e.idx, out_corner_index);
          errors++;
        end
        if (out_last_corner !== e.last) begin
          $display("%0t: last_corner exp %b got %b", $realtime, e.last, out_last_corner);
          errors++;
        end
      end
    end
  end

  // ---- tests ---------------------------------------------------------------
  // Extremes of positions, scales, angles and lanes with given axes.
  task automatic test_given_axes();
    send_sprite(bqe_pkg::OP_GIVEN, 48'h0000_0000_4000, 48'h0000_4000_0000, 0, 0, 0,
                31'h0001_0000, 31'h0001_0000, 16'sd0, 16'sd16384, 32'h1122_3344,
                64'h8000_0000_8000_0000);
    send_sprite(bqe_pkg::OP_GIVEN, 48'h0, 48'h0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                31'h0, 31'h0, 16'sd0, 16'sd0, 32'h0, 64'h0);
    // positive and negative saturation of corners
    send_sprite(bqe_pkg::OP_GIVEN, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 32'sh7FFF_0000,
                32'sh8000_1000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sprite(bqe_pkg::OP_GIVEN, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                16'sh7FFF, 16'sh8000, 32'hA5A5_5A5A, 64'h1234_5678_9ABC_DEF0);
    // rounding: half_width 1 against a 2^28 sum of two 2^27 products
    send_sprite(bqe_pkg::OP_GIVEN, 48'h0000_0000_2000, 48'h0000_0000_E000, 32'sd5,
                -32'sd5, 0, 31'd1, 31'd1, 16'sd16384, -16'sd16384, 32'h0F0F_F0F0,
                64'h0123_4567_89AB_CDEF);
    send_sprite(bqe_pkg::OP_GIVEN, 48'hC000_4000_C000, 48'h4000_C000_4000, 32'sd100,
                32'sd200, -32'sd300, 31'd3, 31'd7, -16'sd16384, 16'sd16384, 32'h5555_AAAA,
                64'h7FFF_0001_8000_FFFF);
  endtask

  // Right axis derived from direction and the camera, with special cases.
  task automatic test_derived_axes();
    // direction parallel to the camera: zero cross product
    send_sprite(bqe_pkg::OP_DERIVE, 48'h4000_0000_0000, rand48(), 32'sd1000, 0, 0,
                31'h0002_0000, 31'h0002_0000, 16'sd0, 16'sd16384, 32'h0, 64'h0);
    send_sprite(bqe_pkg::OP_DERIVE, 48'h0, rand48(), 0, 0, 0, 31'h7FFF_FFFF,
                31'h7FFF_FFFF, 16'sd16384, 16'sd16384, 32'h1, 64'h1);
    // tiny cross products give a coarse root
    send_sprite(bqe_pkg::OP_DERIVE, 48'h0000_0000_0001, 48'h0, 0, 0, 0, 31'h0001_0000,
                31'h0001_0000, 16'sd0, 16'sd16384, 32'h2, 64'h2);
    send_sprite(bqe_pkg::OP_DERIVE, 48'h0000_0001_0001, 48'h0, 0, 0, 0, 31'h0001_0000,
                31'h0001_0000, 16'sd11585, 16'sd11585, 32'h3, 64'h3);
    send_sprite(bqe_pkg::OP_DERIVE, 48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF,
                32'sh7FFF_FFFF, 32'sh8000_0000, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                16'sh8000, 16'sh8000, 32'hDEAD_BEEF, 64'hFFFF_0000_FFFF_0000);
    send_sprite(bqe_pkg::OP_DERIVE, 48'h7FFF_7FFF_7FFF, 48'h0, 0, 0, 0, 31'h0001_0000,
                31'h0001_0000, 16'sh7FFF, 16'sh7FFF, 32'h4, 64'h4);
    send_sprite(bqe_pkg::OP_DERIVE, 48'h0000_0000_4000, 48'h0, 0, 0, 0, 31'h0001_0000,
                31'h0001_0000, 16'sd0, 16'sd16384, 32'h5, 64'h5);
  endtask

  task automatic test_random_mix(int n);
    for (int i = 0; i < n; i++)
      send_random($urandom_range(2) == 0 ? bqe_pkg::OP_DERIVE : bqe_pkg::OP_GIVEN);
  endtask

  // Same mix with no idling on either side.
  task automatic test_back_to_back(int n);
    sender_quiet = 1;
    receiver_quiet = 1;
    test_random_mix(n);
    drain();
    sender_quiet = 0;
    receiver_quiet = 0;
  endtask

  // Derived axes under several camera settings, extremes included.
  task automatic test_camera_settings();
    logic [47:0] cams[5];
    cams[0] = 48'h0000_0000_4000;
    cams[1] = 48'h7FFF_7FFF_7FFF;
    cams[2] = 48'h8000_8000_8000;
    cams[3] = 48'h0;
    cams[4] = rand48();
    foreach (cams[j]) begin
      drain();
      write_camera(cams[j]);
      send_sprite(bqe_pkg::OP_DERIVE, 48'h0000_0000_4000, 48'h0, 0, 0, 0, 31'h0001_0000,
                  31'h0001_0000, 16'sd0, 16'sd16384, 32'h6, 64'h6);
      test_random_mix(8);
    end
    drain();
    write_camera(48'hFFFF_FFFF_FFFF);
    test_random_mix(6);
  endtask

  initial begin
    camera_dir = bqe_pkg::BQE_CAM_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_given_axes();
    test_derived_axes();
    test_random_mix(30);
    test_back_to_back(16);
    test_camera_settings();
    push <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bqe_pkg.sv
rtl/bqe_queue.sv
rtl/bqe_front.sv
rtl/bqe_back.sv
rtl/billboard_quad_expander_core.sv
tb/tb_billboard_quad_expander_core.sv
